// ===== rtl/cstl_pkg.sv =====
`timescale 1ns / 1ps

package cstl_pkg;

  // Widest slot index carried between modules (table holds at most 64 slots)
  localparam int IDX_W = 6;
  localparam int DEFAULT_SLOT_COUNT = 8;

  // Idle timeout after reset, in milliseconds
  localparam logic [31:0] IDLE_TIMEOUT_RESET = 32'd30000;

  // Transaction kinds
  localparam logic [3:0] KIND_ALLOC     = 4'd0;
  localparam logic [3:0] KIND_ADDREF    = 4'd1;
  localparam logic [3:0] KIND_RELEASE   = 4'd2;
  localparam logic [3:0] KIND_PEER_FIN  = 4'd3;
  localparam logic [3:0] KIND_ERROR     = 4'd4;
  localparam logic [3:0] KIND_POLL      = 4'd5;
  localparam logic [3:0] KIND_ACTIVITY  = 4'd6;
  localparam logic [3:0] KIND_ATTACH    = 4'd7;
  localparam logic [3:0] KIND_ABORT_ALL = 4'd8;
  localparam logic [3:0] KIND_MARK      = 4'd9;

  // Slot states
  localparam logic [1:0] ST_FREE        = 2'd0;
  localparam logic [1:0] ST_CONNECTING  = 2'd1;
  localparam logic [1:0] ST_ESTABLISHED = 2'd2;
  localparam logic [1:0] ST_PEER_CLOSED = 2'd3;

  // Close requests
  localparam logic [1:0] CLOSE_NONE     = 2'd0;
  localparam logic [1:0] CLOSE_GRACEFUL = 2'd1;
  localparam logic [1:0] CLOSE_ABORT    = 2'd2;

  // Connect flags: bit0 done, bit1 ok
  localparam logic [1:0] CF_DONE_FAIL = 2'b01;

  typedef struct packed {
    logic [3:0]  kind;
    logic [2:0]  slot;
    logic [31:0] now_ms;
    logic        allow_evict;
    logic        claim_value;
    logic [15:0] port_value;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [2:0]  slot_out;
    logic        evicted;
    logic        freed;
    logic [1:0]  close_action;
    logic [7:0]  aborted_mask;
    logic [31:0] eviction_count;
    logic [1:0]  slot_state;
    logic [7:0]  ref_count;
  } out_item_t;

  // Carry handed from cell to cell: first free slot and oldest victim so far
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] free_idx;
    logic             have;
    logic [IDX_W-1:0] vic_idx;
    logic [31:0]      vic_time;
  } scan_t;

  // Command broadcast to every cell
  typedef struct packed {
    logic             apply;
    logic [3:0]       kind;
    logic             hit;
    logic [IDX_W-1:0] target;
    logic [31:0]      now_ms;
    logic             claim_value;
    logic [15:0]      port_value;
    logic [31:0]      timeout;
  } cmd_t;

  // Per-cell report, all zero unless the cell is the target
  typedef struct packed {
    logic       ignored;
    logic       freed;
    logic [1:0] close_action;
    logic [1:0] slot_state;
    logic [7:0] ref_count;
  } rpt_t;

endpackage

// ===== rtl/cstl_cell.sv =====
`timescale 1ns / 1ps

module cstl_cell import cstl_pkg::*; #(
  parameter int INDEX = 0
) (
  input  logic  clk,
  input  logic  rst,
  input  cmd_t  cmd,
  input  scan_t scan_in,
  output scan_t scan_out,
  output rpt_t  rpt,
  output logic  aborted
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [1:0]  st, st_next;
  logic        live, live_next;
  logic [7:0]  rc, rc_next;
  logic        clm, clm_next;
  logic [15:0] port, port_next;
  logic [31:0] at, at_next;
  logic [1:0]  cf, cf_next;

  logic        match;
  logic        do_free;
  logic        do_alloc;
  logic        idle_exp;
  logic [31:0] age;
  logic [31:0] gap;
  scan_t       scan_next;

  // Advance the scan carry: first free slot, oldest evictable slot
  always_comb begin
    scan_next = scan_in;
    gap       = scan_in.vic_time - at;
    if (!scan_in.found && st == ST_FREE) begin
      scan_next.found    = 1'b1;
      scan_next.free_idx = MY_IDX;
    end
    if (!clm && port != 16'd0) begin
      if (!scan_in.have || (gap != 32'd0 && !gap[31])) begin
        scan_next.have     = 1'b1;
        scan_next.vic_idx  = MY_IDX;
        scan_next.vic_time = at;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_out <= scan_next;
  end

  assign match    = cmd.hit && (cmd.target == MY_IDX);
  assign age      = cmd.now_ms - at;
  assign idle_exp = age > cmd.timeout;

  // Apply the broadcast command to this slot
  always_comb begin
    st_next   = st;
    live_next = live;
    rc_next   = rc;
    clm_next  = clm;
    port_next = port;
    at_next   = at;
    cf_next   = cf;
    do_free   = 1'b0;
    do_alloc  = 1'b0;
    aborted   = 1'b0;
    rpt       = '0;
    if (cmd.apply) begin
      if (cmd.kind == KIND_ABORT_ALL) begin
        if (st != ST_FREE && live) begin
          aborted   = 1'b1;
          live_next = 1'b0;
          st_next   = ST_PEER_CLOSED;
          cf_next   = CF_DONE_FAIL;
          if (rc == 8'd0) begin
            do_free   = 1'b1;
            rpt.freed = match;
          end
        end
      end else if (match) begin
        case (cmd.kind)
          KIND_ALLOC: begin
            rpt.close_action = live ? CLOSE_GRACEFUL : CLOSE_NONE;
            do_free          = 1'b1;
            do_alloc         = 1'b1;
          end
          KIND_RELEASE: begin
            if (rc == 8'd0) begin
              rpt.ignored = 1'b1;
            end else begin
              rc_next = rc - 8'd1;
              if (rc == 8'd1) begin
                rpt.close_action = live ? CLOSE_GRACEFUL : CLOSE_NONE;
                rpt.freed        = 1'b1;
                do_free          = 1'b1;
              end
            end
          end
          default: begin
            if (st == ST_FREE) begin
              rpt.ignored = 1'b1;
            end else if ((cmd.kind inside {KIND_PEER_FIN, KIND_ERROR, KIND_POLL}) && !live) begin
              rpt.ignored = 1'b1;
            end else begin
              case (cmd.kind)
                KIND_ADDREF: begin
                  if (rc != 8'hFF) begin
                    rc_next = rc + 8'd1;
                  end
                end
                KIND_PEER_FIN: begin
                  st_next = ST_PEER_CLOSED;
                end
                KIND_ERROR: begin
                  live_next = 1'b0;
                  st_next   = ST_PEER_CLOSED;
                  cf_next   = CF_DONE_FAIL;
                  if (rc == 8'd0) begin
                    do_free   = 1'b1;
                    rpt.freed = 1'b1;
                  end
                end
                KIND_POLL: begin
                  if (!clm && rc == 8'd0 && idle_exp) begin
                    do_free          = 1'b1;
                    rpt.freed        = 1'b1;
                    rpt.close_action = CLOSE_ABORT;
                  end
                end
                KIND_ACTIVITY: begin
                  at_next = cmd.now_ms;
                end
                KIND_ATTACH: begin
                  live_next = 1'b1;
                  at_next   = cmd.now_ms;
                end
                KIND_MARK: begin
                  clm_next  = cmd.claim_value;
                  port_next = cmd.port_value;
                  st_next   = ST_ESTABLISHED;
                end
                default: begin
                  rpt.ignored = 1'b1;
                end
              endcase
            end
          end
        endcase
      end
      // Return the slot to free, keeping the activity time
      if (do_free) begin
        st_next   = ST_FREE;
        live_next = 1'b0;
        rc_next   = 8'd0;
        clm_next  = 1'b0;
        port_next = 16'd0;
        cf_next   = 2'd0;
      end
      if (do_alloc) begin
        st_next = ST_CONNECTING;
      end
      if (match) begin
        rpt.slot_state = st_next;
        rpt.ref_count  = rc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= ST_FREE;
      live <= 1'b0;
      rc   <= 8'd0;
      clm  <= 1'b0;
      port <= 16'd0;
      at   <= 32'd0;
      cf   <= 2'd0;
    end else begin
      st   <= st_next;
      live <= live_next;
      rc   <= rc_next;
      clm  <= clm_next;
      port <= port_next;
      at   <= at_next;
      cf   <= cf_next;
    end
  end

  // A free slot holds no references, claim, port or link
  a_free_clean: assert property (@(posedge clk) disable iff (rst)
    (st == ST_FREE) |-> (rc == 8'd0 && !live && !clm && port == 16'd0))
    else $error("free slot holds stale fields");

  // Only the targeted cell reports back
  a_rpt_target: assert property (@(posedge clk) disable iff (rst)
    !match |-> (rpt == '0 || (cmd.apply && cmd.kind == KIND_ABORT_ALL && rpt.freed == 1'b0 &&
                rpt == '0)))
    else $error("report from a cell that is not the target");

  // Abort clears the link of this slot
  a_abort_drop: assert property (@(posedge clk) disable iff (rst)
    aborted |=> !live)
    else $error("aborted slot still live");

endmodule

// ===== rtl/cstl_ctrl.sv =====
`timescale 1ns / 1ps

module cstl_ctrl import cstl_pkg::*; #(
  parameter int SLOT_COUNT = DEFAULT_SLOT_COUNT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [31:0]           cfg_data,
  output cmd_t                  cmd,
  input  scan_t                 scan_tail,
  input  rpt_t                  rpt [SLOT_COUNT],
  input  logic [SLOT_COUNT-1:0] aborted
);

  localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
  localparam int MASK_N = (SLOT_COUNT < 8) ? SLOT_COUNT : 8;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WAIT,
    S_APPLY
  } state_t;

  state_t      state;
  in_item_t    item;
  logic [CNT_W-1:0] settle;
  logic [31:0] evict_cnt;
  logic [31:0] evict_cnt_next;
  logic [31:0] timeout;

  logic        go;
  logic        is_alloc;
  logic        is_abort;
  logic        slot_ok;
  logic        evict_hit;
  rpt_t        rsum;
  out_item_t   res;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign go        = (state == S_APPLY) && (!out_valid || out_ready);
  assign is_alloc  = (item.kind == KIND_ALLOC);
  assign is_abort  = (item.kind == KIND_ABORT_ALL);
  assign slot_ok   = (SLOT_COUNT > 7) || (item.slot < 3'(SLOT_COUNT));
  assign evict_hit = !scan_tail.found && item.allow_evict && scan_tail.have;

  // Build the command broadcast to the cells
  always_comb begin
    cmd             = '0;
    cmd.apply       = go;
    cmd.kind        = item.kind;
    cmd.now_ms      = item.now_ms;
    cmd.claim_value = item.claim_value;
    cmd.port_value  = item.port_value;
    cmd.timeout     = timeout;
    if (is_alloc) begin
      cmd.hit    = scan_tail.found || evict_hit;
      cmd.target = scan_tail.found ? scan_tail.free_idx :
                   (evict_hit ? scan_tail.vic_idx : '0);
    end else begin
      // Unknown kinds still target the slot so that it reports its state
      cmd.hit    = slot_ok;
      cmd.target = IDX_W'(item.slot);
    end
  end

  // Collect the target's report
  always_comb begin
    rsum = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      rsum = rpt_t'(rsum | rpt[i]);
    end
  end

  // Assemble the result transaction
  always_comb begin
    res                = '0;
    res.evicted        = is_alloc && evict_hit;
    evict_cnt_next     = evict_cnt + 32'(res.evicted);
    res.eviction_count = evict_cnt_next;
    res.freed          = rsum.freed;
    res.slot_state     = rsum.slot_state;
    res.ref_count      = rsum.ref_count;
    res.slot_out       = is_alloc ? cmd.target[2:0] : item.slot;
    if (is_alloc) begin
      res.status       = !cmd.hit;
      res.close_action = rsum.close_action;
    end else if (is_abort) begin
      res.status       = 1'b0;
      res.close_action = (|aborted) ? CLOSE_ABORT : CLOSE_NONE;
      res.aborted_mask[MASK_N-1:0] = aborted[MASK_N-1:0];
    end else begin
      res.status       = !cmd.hit || rsum.ignored;
      res.close_action = rsum.close_action;
    end
  end

  // Sequence one transaction at a time; hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      settle    <= CNT_W'(SLOT_COUNT);
      evict_cnt <= 32'd0;
      timeout   <= IDLE_TIMEOUT_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        timeout <= cfg_data;
      end
      if (go) begin
        settle <= CNT_W'(SLOT_COUNT);
      end else if (settle != '0) begin
        settle <= settle - CNT_W'(1);
      end
      if (go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            item  <= in_data;
            state <= (in_data.kind == KIND_ALLOC) ? S_WAIT : S_APPLY;
          end
        end
        S_WAIT: begin
          if (settle == '0) begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (go) begin
            out_data  <= res;
            evict_cnt <= evict_cnt_next;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Alloc only reads a settled scan chain
  a_alloc_settled: assert property (@(posedge clk) disable iff (rst)
    (go && is_alloc) |-> (settle == '0))
    else $error("alloc applied before scan chain settled");

  // Every applied transaction yields a result
  a_go_result: assert property (@(posedge clk) disable iff (rst)
    go |=> out_valid)
    else $error("applied transaction produced no result");

  // Eviction total moves by at most one per transaction
  a_evict_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (evict_cnt == $past(evict_cnt) || evict_cnt == $past(evict_cnt) + 32'd1))
    else $error("eviction count jumped");

  // An eviction is a successful alloc that never aborts
  a_evict_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.evicted) |-> (!out_data.status && !out_data.freed &&
                                         out_data.close_action != CLOSE_ABORT))
    else $error("inconsistent eviction result");

endmodule

// ===== rtl/connection_slot_table_lru_evict_core.sv =====
`timescale 1ns / 1ps

// Connection slot table with LRU eviction and reference counts.
// Input channel (in_valid/in_ready/in_data) takes one transaction; output
// channel (out_valid/out_ready/out_data) returns exactly one result for it.
// cfg_valid/cfg_ready/cfg_data writes the idle timeout (ms); cfg_ready is
// always high. Write it only while the table is idle.
// The table is a chain of SLOT_COUNT cells. Each cycle every cell passes a
// scan carry (first free slot, oldest evictable slot) to its neighbor, so the
// chain settles once the carry from the last slot update has passed every cell.
// A non-alloc item goes from the idle state to the apply step, where its
// result is registered once the output is free. An alloc first waits for
// the scan chain to settle, then applies the same way. One transaction is
// in work at a time; in_ready drops after acceptance and is high again in
// the cycle the result appears, so the next transaction may enter while the
// result waits. If the receiver stalls with a result still held, the next
// one waits in the apply step and the table does not change.
// Reset (rst, synchronous) frees all slots, clears the eviction count and
// loads the idle timeout with 30000.
module connection_slot_table_lru_evict_core import cstl_pkg::*; #(
  parameter int SLOT_COUNT = DEFAULT_SLOT_COUNT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  cmd_t                  cmd;
  scan_t                 chain [SLOT_COUNT+1];
  rpt_t                  rpt   [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] aborted;

  // Seed the head of the scan chain
  assign chain[0] = '0;

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    cstl_cell #(
      .INDEX(i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .cmd     (cmd),
      .scan_in (chain[i]),
      .scan_out(chain[i+1]),
      .rpt     (rpt[i]),
      .aborted (aborted[i])
    );
  end

  cstl_ctrl #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .scan_tail(chain[SLOT_COUNT]),
    .rpt      (rpt),
    .aborted  (aborted)
  );

endmodule

// ===== sim/tb_connection_slot_table_lru_evict_core.sv =====
`timescale 1ns / 1ps

module tb_connection_slot_table_lru_evict_core;
  import cstl_pkg::*;

  localparam int SLOTS = DEFAULT_SLOT_COUNT;
  localparam int SETTLE = 2 * SLOTS + 8;
  localparam int PHASE_ITEMS = 190;
  localparam int CYCLE_LIMIT = 500000;
  localparam int NUM_PHASES = 5;
  localparam logic STAT_DONE = 1'b0;
  localparam logic STAT_IGNORED = 1'b1;

  // Directed stimulus row; want is used only when typed is set
  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  // Shadow copy of the slot table
  logic [1:0]  tbl_state [SLOTS];
  logic        tbl_live  [SLOTS];
  logic [7:0]  tbl_refs  [SLOTS];
  logic        tbl_claim [SLOTS];
  logic [15:0] tbl_port  [SLOTS];
  logic [31:0] tbl_time  [SLOTS];
  logic [1:0]  tbl_conn  [SLOTS];
  logic [31:0] evict_total;
  logic [31:0] idle_limit;

  out_item_t   slot_results_due [$];
  dir_row_t    dir_rows [$];
  logic [31:0] cfg_plan [NUM_PHASES];
  logic [31:0] t_base = '0;
  int          errors = 0;
  int          sent = 0;
  int          burst_left = 0;
  int          cycle_count = 0;
  int          rx_mode = 0;
  int          mode_left = 0;
  int          hold_left = 0;
  logic        hold_val = 1'b0;

  connection_slot_table_lru_evict_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Return a slot to free; the activity time survives
  function automatic void free_slot(input int i);
    tbl_state[i] = ST_FREE;
    tbl_live[i]  = 1'b0;
    tbl_refs[i]  = '0;
    tbl_claim[i] = 1'b0;
    tbl_port[i]  = '0;
    tbl_conn[i]  = '0;
  endfunction

  // Close a live link; free it when nobody holds a reference
  function automatic bit drop_conn(input int i);
    tbl_live[i]  = 1'b0;
    tbl_state[i] = ST_PEER_CLOSED;
    tbl_conn[i]  = CF_DONE_FAIL;
    if (tbl_refs[i] == 8'd0) begin
      free_slot(i);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void clear_table();
    int i;
    for (i = 0; i < SLOTS; i++) begin
      free_slot(i);
      tbl_time[i] = '0;
    end
    evict_total = '0;
    idle_limit = IDLE_TIMEOUT_RESET;
  endfunction

  // Apply one transaction to the shadow table and build its result
  function automatic out_item_t predict_table_op(input in_item_t it);
    out_item_t   r;
    int          s;
    int          i;
    int          v;
    bit          ok;
    bit          found;
    bit          have;
    logic [31:0] d;
    r = '0;
    s = int'(it.slot);
    ok = (s < SLOTS);
    found = 1'b0;
    have = 1'b0;
    v = 0;
    if (it.kind == KIND_ALLOC) begin
      for (i = 0; i < SLOTS; i++) begin
        if (!found && tbl_state[i] == ST_FREE) begin
          found = 1'b1;
          s = i;
        end
      end
      if (found) begin
        tbl_state[s] = ST_CONNECTING;
        ok = 1'b1;
      end else if (it.allow_evict) begin
        // Oldest unclaimed accepted slot, wrap-safe compare, first one wins ties
        for (i = 0; i < SLOTS; i++) begin
          if (tbl_claim[i] || tbl_port[i] == 16'd0) continue;
          d = tbl_time[v] - tbl_time[i];
          if (!have || (d != 32'd0 && !d[31])) begin
            v = i;
            have = 1'b1;
          end
        end
        if (have) begin
          evict_total = evict_total + 32'd1;
          if (tbl_live[v]) r.close_action = CLOSE_GRACEFUL;
          free_slot(v);
          tbl_state[v] = ST_CONNECTING;
          r.evicted = 1'b1;
          s = v;
          ok = 1'b1;
        end else begin
          r.status = STAT_IGNORED;
          s = 0;
          ok = 1'b0;
        end
      end else begin
        r.status = STAT_IGNORED;
        s = 0;
        ok = 1'b0;
      end
    end else if (it.kind == KIND_ABORT_ALL) begin
      for (i = 0; i < SLOTS; i++) begin
        if (tbl_state[i] == ST_FREE || !tbl_live[i]) continue;
        if (drop_conn(i) && i == s) r.freed = 1'b1;
        if (i < 8) r.aborted_mask[i] = 1'b1;
        r.close_action = CLOSE_ABORT;
      end
    end else if (it.kind > KIND_MARK || !ok) begin
      r.status = STAT_IGNORED;
    end else if (it.kind == KIND_RELEASE) begin
      if (tbl_refs[s] == 8'd0) begin
        r.status = STAT_IGNORED;
      end else begin
        tbl_refs[s] = tbl_refs[s] - 8'd1;
        if (tbl_refs[s] == 8'd0) begin
          if (tbl_live[s]) r.close_action = CLOSE_GRACEFUL;
          free_slot(s);
          r.freed = 1'b1;
        end
      end
    end else if (tbl_state[s] == ST_FREE) begin
      r.status = STAT_IGNORED;
    end else if ((it.kind == KIND_PEER_FIN || it.kind == KIND_ERROR ||
                  it.kind == KIND_POLL) && !tbl_live[s]) begin
      r.status = STAT_IGNORED;
    end else begin
      case (it.kind)
        KIND_ADDREF: begin
          if (tbl_refs[s] != 8'hFF) tbl_refs[s] = tbl_refs[s] + 8'd1;
        end
        KIND_PEER_FIN: begin
          tbl_state[s] = ST_PEER_CLOSED;
        end
        KIND_ERROR: begin
          r.freed = drop_conn(s);
        end
        KIND_POLL: begin
          d = it.now_ms - tbl_time[s];
          if (!tbl_claim[s] && tbl_refs[s] == 8'd0 && d > idle_limit) begin
            free_slot(s);
            r.freed = 1'b1;
            r.close_action = CLOSE_ABORT;
          end
        end
        KIND_ACTIVITY: begin
          tbl_time[s] = it.now_ms;
        end
        KIND_ATTACH: begin
          tbl_live[s] = 1'b1;
          tbl_time[s] = it.now_ms;
        end
        default: begin
          tbl_claim[s] = it.claim_value;
          tbl_port[s] = it.port_value;
          tbl_state[s] = ST_ESTABLISHED;
        end
      endcase
    end
    r.slot_out = s[2:0];
    r.eviction_count = evict_total;
    if (ok) begin
      r.slot_state = tbl_state[s];
      r.ref_count = tbl_refs[s];
    end
    return r;
  endfunction

  function automatic in_item_t mk_in(input logic [3:0] kind, input logic [2:0] slot,
                                     input logic [31:0] now, input logic allow,
                                     input logic claim, input logic [15:0] port);
    in_item_t it;
    it.kind = kind;
    it.slot = slot;
    it.now_ms = now;
    it.allow_evict = allow;
    it.claim_value = claim;
    it.port_value = port;
    return it;
  endfunction

  function automatic out_item_t mk_out(input logic status, input logic [2:0] slot,
                                       input logic [1:0] state);
    out_item_t r;
    r = '0;
    r.status = status;
    r.slot_out = slot;
    r.slot_state = state;
    return r;
  endfunction

  function automatic void add_row(input in_item_t it, input bit typed, input out_item_t want);
    dir_row_t row;
    row.item = it;
    row.typed = typed;
    row.want = want;
    dir_rows.push_back(row);
  endfunction

  // Random single bit and random 16-bit word
  function automatic logic coin();
    return 1'($urandom);
  endfunction

  function automatic logic [15:0] word16();
    return 16'($urandom);
  endfunction

  // Advance the time base, now and then jumping anywhere in the 32-bit range
  function automatic logic [31:0] next_now();
    if ($urandom_range(0, 15) == 0) t_base = $urandom;
    else t_base = t_base + $urandom_range(0, 3000);
    return t_base;
  endfunction

  function automatic logic [15:0] pick_port();
    case ($urandom_range(0, 7))
      0: begin
        return 16'd0;
      end
      1: begin
        return 16'hFFFF;
      end
      default: begin
        return word16();
      end
    endcase
  endfunction

  function automatic logic [3:0] pick_mid_kind();
    case ($urandom_range(0, 5))
      0: begin
        return KIND_ACTIVITY;
      end
      1: begin
        return KIND_RELEASE;
      end
      2: begin
        return KIND_POLL;
      end
      3: begin
        return KIND_PEER_FIN;
      end
      default: begin
        return KIND_ADDREF;
      end
    endcase
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    if (errors <= 50)
      $display("[%0t] %s mismatch: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
  endtask

  // Compare one result with the oldest one due
  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (slot_results_due.size() == 0) begin
      report("unexpected result, slot_out", 32'(got.slot_out), 32'd0);
      return;
    end
    want = slot_results_due.pop_front();
    if (got.status != want.status)
      report("status", 32'(got.status), 32'(want.status));
    if (got.slot_out != want.slot_out)
      report("slot_out", 32'(got.slot_out), 32'(want.slot_out));
    if (got.evicted != want.evicted)
      report("evicted", 32'(got.evicted), 32'(want.evicted));
    if (got.freed != want.freed)
      report("freed", 32'(got.freed), 32'(want.freed));
    if (got.close_action != want.close_action)
      report("close_action", 32'(got.close_action), 32'(want.close_action));
    if (got.aborted_mask != want.aborted_mask)
      report("aborted_mask", 32'(got.aborted_mask), 32'(want.aborted_mask));
    if (got.eviction_count != want.eviction_count)
      report("eviction_count", got.eviction_count, want.eviction_count);
    if (got.slot_state != want.slot_state)
      report("slot_state", 32'(got.slot_state), 32'(want.slot_state));
    if (got.ref_count != want.ref_count)
      report("ref_count", 32'(got.ref_count), 32'(want.ref_count));
  endtask

  // Offer one transaction in bursts with gaps; queue its result once accepted
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t want,
                           output out_item_t res);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    res = predict_table_op(it);
    if (typed) slot_results_due.push_back(want);
    else slot_results_due.push_back(res);
    sent++;
  endtask

  task automatic send_pred(input in_item_t it, output out_item_t res);
    send_item(it, 1'b0, '0, res);
  endtask

  // Hold off until every result is back and the scan chain has settled
  task automatic drain();
    in_valid <= 1'b0;
    while (slot_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [31:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    idle_limit = value;
  endtask

  // One connection lifetime: reserve, attach, maybe mark, traffic, then a close or left open
  task automatic run_session();
    out_item_t   res;
    logic [2:0]  sl;
    int          steps;
    send_pred(mk_in(KIND_ALLOC, 3'($urandom), next_now(), ($urandom_range(0, 7) != 0),
                    coin(), word16()), res);
    if (res.status == STAT_IGNORED) return;
    sl = res.slot_out;
    send_pred(mk_in(KIND_ATTACH, sl, next_now(), coin(), coin(), word16()), res);
    if ($urandom_range(0, 3) != 0)
      send_pred(mk_in(KIND_MARK, sl, next_now(), coin(), ($urandom_range(0, 3) == 0),
                      pick_port()), res);
    steps = $urandom_range(0, 5);
    repeat (steps)
      send_pred(mk_in(pick_mid_kind(), sl, next_now(), coin(), coin(), word16()), res);
    case ($urandom_range(0, 4))
      0: begin
        send_pred(mk_in(KIND_ERROR, sl, next_now(), coin(), coin(), word16()), res);
      end
      1: begin
        // Poll right at the timeout boundary or just past it
        send_pred(mk_in(KIND_POLL, sl, tbl_time[sl] + idle_limit + $urandom_range(0, 2),
                        coin(), coin(), word16()), res);
      end
      2: begin
        send_pred(mk_in(KIND_RELEASE, sl, next_now(), coin(), coin(), word16()), res);
      end
      default: begin
      end
    endcase
  endtask

  // Receiver: checks each result taken; the stall pattern switches mode at random
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) check_result(out_data);
    if (hold_left == 0) begin
      case (rx_mode)
        0: begin
          hold_val = 1'b1;
          hold_left = 32;
        end
        1: begin
          hold_val = ($urandom_range(0, 3) != 0);
          hold_left = 1;
        end
        default: begin
          hold_val = ~hold_val;
          hold_left = hold_val ? $urandom_range(1, 6) : $urandom_range(1, 16);
        end
      endcase
    end
    hold_left--;
    out_ready <= hold_val;
    if (mode_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(50, 400);
    end else begin
      mode_left--;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_connection_slot_table_lru_evict_core: errors");
      $finish;
    end
  end

  initial begin
    out_item_t res;
    int        ph;
    int        target;
    int        k;
    int        sl;
    bit        paused;

    clear_table();
    cfg_plan[0] = 32'd0;
    cfg_plan[1] = 32'hFFFF_FFFF;
    cfg_plan[2] = 32'd2000;
    cfg_plan[3] = $urandom_range(100, 100000);
    cfg_plan[4] = IDLE_TIMEOUT_RESET;
    paused = 1'b0;

    // Directed rows: lifecycle on slot 0, fill the table, then evict, abort and an unknown kind
    add_row(mk_in(KIND_ALLOC, 3'd5, 32'd0, 1'b0, 1'b0, 16'd0), 1'b1,
            mk_out(STAT_DONE, 3'd0, ST_CONNECTING));
    add_row(mk_in(KIND_ADDREF, 3'd7, 32'd0, 1'b0, 1'b0, 16'd0), 1'b1,
            mk_out(STAT_IGNORED, 3'd7, ST_FREE));
    add_row(mk_in(KIND_RELEASE, 3'd3, 32'd0, 1'b0, 1'b0, 16'd0), 1'b1,
            mk_out(STAT_IGNORED, 3'd3, ST_FREE));
    add_row(mk_in(KIND_POLL, 3'd0, 32'hFFFF_FFFF, 1'b1, 1'b1, 16'hFFFF), 1'b1,
            mk_out(STAT_IGNORED, 3'd0, ST_CONNECTING));
    add_row(mk_in(KIND_ATTACH, 3'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, 16'd0), 1'b0, '0);
    add_row(mk_in(KIND_MARK, 3'd0, 32'd0, 1'b0, 1'b0, 16'hFFFF), 1'b0, '0);
    add_row(mk_in(KIND_ADDREF, 3'd0, 32'd0, 1'b0, 1'b0, 16'd0), 1'b0, '0);
    add_row(mk_in(KIND_PEER_FIN, 3'd0, 32'd0, 1'b0, 1'b0, 16'd0), 1'b0, '0);
    add_row(mk_in(KIND_POLL, 3'd0, 32'h0000_7530, 1'b0, 1'b0, 16'd0), 1'b0, '0);
    add_row(mk_in(KIND_RELEASE, 3'd0, 32'd0, 1'b0, 1'b0, 16'd0), 1'b0, '0);
    for (k = 0; k < SLOTS; k++)
      add_row(mk_in(KIND_ALLOC, 3'd7, 32'd0, k[0], 1'b0, 16'd0), 1'b0, '0);
    add_row(mk_in(KIND_MARK, 3'd3, 32'd0, 1'b0, 1'b1, 16'h0050), 1'b0, '0);
    add_row(mk_in(KIND_MARK, 3'd5, 32'd0, 1'b0, 1'b0, 16'h0001), 1'b0, '0);
    add_row(mk_in(KIND_ATTACH, 3'd5, 32'd0, 1'b0, 1'b0, 16'd0), 1'b0, '0);
    add_row(mk_in(KIND_MARK, 3'd7, 32'd0, 1'b0, 1'b0, 16'h8000), 1'b0, '0);
    add_row(mk_in(KIND_ALLOC, 3'd0, 32'd0, 1'b0, 1'b0, 16'd0), 1'b1,
            mk_out(STAT_IGNORED, 3'd0, ST_FREE));
    add_row(mk_in(KIND_ALLOC, 3'd0, 32'd0, 1'b1, 1'b0, 16'd0), 1'b0, '0);
    add_row(mk_in(KIND_ATTACH, 3'd3, 32'h1234_5678, 1'b0, 1'b0, 16'd0), 1'b0, '0);
    add_row(mk_in(KIND_ABORT_ALL, 3'd3, 32'd0, 1'b0, 1'b0, 16'd0), 1'b0, '0);
    add_row(mk_in(4'hF, 3'd2, 32'hFFFF_FFFF, 1'b1, 1'b1, 16'hFFFF), 1'b0, '0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[k])
      send_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want, res);

    // Random phases, one timeout setting each
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      write_timeout(cfg_plan[ph]);
      target = sent + PHASE_ITEMS;
      while (sent < target) begin
        if (ph == 2 && !paused && sent >= target - PHASE_ITEMS / 2) begin
          drain();
          paused = 1'b1;
        end
        if ($urandom_range(0, 9) < 6)
          run_session();
        else
          send_pred(mk_in(4'($urandom), 3'($urandom),
                          ($urandom_range(0, 1) == 0) ? $urandom : next_now(),
                          coin(), coin(), word16()), res);
      end
      if (ph == 1) begin
        // Drive one slot's reference count into saturation and back to free
        sl = -1;
        for (k = 0; k < SLOTS; k++)
          if (sl < 0 && tbl_state[k] != ST_FREE) sl = k;
        if (sl < 0) begin
          send_pred(mk_in(KIND_ALLOC, 3'd0, next_now(), 1'b1, 1'b0, 16'd0), res);
          sl = int'(res.slot_out);
        end
        repeat (258)
          send_pred(mk_in(KIND_ADDREF, 3'(sl), next_now(), coin(), coin(), word16()), res);
        repeat (256)
          send_pred(mk_in(KIND_RELEASE, 3'(sl), next_now(), coin(), coin(), word16()), res);
      end
    end

    drain();
    if (errors == 0) begin
      $display("tb_connection_slot_table_lru_evict_core: clean");
    end else begin
      $display("tb_connection_slot_table_lru_evict_core: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/cstl_pkg.sv
rtl/cstl_cell.sv
rtl/cstl_ctrl.sv
rtl/connection_slot_table_lru_evict_core.sv
sim/tb_connection_slot_table_lru_evict_core.sv
